/* rtl/core/bss_pkg.sv */
package bss_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int VALUE_W      = 32;
  localparam int FUNC_W       = 2;
  localparam int MCOUNT_W     = 9;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic scan;
    logic rd_last;
    logic move;
    logic apply;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic del_hit;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/bss_ram.sv */
module bss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/bss_ctrl.sv */
module bss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bss_pkg::status_t status,
  output bss_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_LAST  = 6'b000100,
    S_MOVE  = 6'b001000,
    S_APPLY = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = status.del_hit ? S_LAST : S_APPLY;
        end
      end
      S_LAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_DONE;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/bss_dp.sv */
module bss_dp #(
  parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [bss_pkg::FUNC_W-1:0]           in_func,
  input  logic signed [bss_pkg::VALUE_W-1:0]   in_value,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 out_success,
  output logic [bss_pkg::MCOUNT_W-1:0]         out_member_count,
  output logic                                 out_set_empty,
  input  bss_pkg::cmd_t                        cmd,
  output bss_pkg::status_t                     status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [bss_pkg::FUNC_W-1:0]          func_r, func_nxt;
  logic signed [bss_pkg::VALUE_W-1:0]  value_r, value_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  logic [CW-1:0]                       idx_r, idx_nxt;
  logic                                cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]                       cmp_idx_r, cmp_idx_nxt;
  logic                                found_r, found_nxt;
  logic [AW-1:0]                       slot_r, slot_nxt;
  logic                                ok_r, ok_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                success_r, success_nxt;
  logic [bss_pkg::MCOUNT_W-1:0]        mcount_r, mcount_nxt;
  logic                                empty_r, empty_nxt;

  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic [bss_pkg::VALUE_W-1:0] wdata, rdata;
  logic [CW-1:0]               last_idx;
  logic                        issue;

  bss_ram #(
    .WIDTH (bss_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign last_idx = count_r - 1'b1;
  assign issue    = (idx_r < count_r);

  // The scan is over once a match is registered, or every stored entry was
  // read and the last read has been compared.
  assign status.scan_done = found_r || (!cmp_vld_r && !issue);
  assign status.del_hit   = (func_r == bss_pkg::FUNC_DELETE) && found_r;
  assign status.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    func_nxt      = func_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    success_nxt   = success_r;
    mcount_nxt    = mcount_r;
    empty_nxt     = empty_r;
    we            = 1'b0;
    waddr         = slot_r;
    wdata         = rdata;
    re            = 1'b0;
    raddr         = idx_r[AW-1:0];

    if (cmd.latch) begin
      func_nxt  = in_func;
      value_nxt = in_value;
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end

    if (cmd.scan) begin
      if (issue) begin
        re          = 1'b1;
        idx_nxt     = idx_r + 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = idx_r[AW-1:0];
      end
      if (cmp_vld_r && !found_r && (rdata == value_r)) begin
        found_nxt = 1'b1;
        slot_nxt  = cmp_idx_r;
      end
    end

    if (cmd.rd_last) begin
      re    = 1'b1;
      raddr = last_idx[AW-1:0];
    end

    // Order is free, so the last entry fills the gap left by the deleted one.
    if (cmd.move) begin
      we        = 1'b1;
      waddr     = slot_r;
      wdata     = rdata;
      count_nxt = last_idx;
      ok_nxt    = 1'b1;
    end

    if (cmd.apply) begin
      case (func_r)
        bss_pkg::FUNC_INSERT: begin
          if (!found_r && (count_r < CW'(CAPACITY))) begin
            we        = 1'b1;
            waddr     = count_r[AW-1:0];
            wdata     = value_r;
            count_nxt = count_r + 1'b1;
            ok_nxt    = 1'b1;
          end else begin
            ok_nxt = 1'b0;
          end
        end
        bss_pkg::FUNC_QUERY: begin
          ok_nxt = found_r;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      success_nxt   = ok_r;
      mcount_nxt    = bss_pkg::MCOUNT_W'(count_r);
      empty_nxt     = (count_r == '0);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    value_r   <= value_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
    ok_r      <= ok_nxt;
    success_r <= success_nxt;
    mcount_r  <= mcount_nxt;
    empty_r   <= empty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_success      = success_r;
  assign out_member_count = mcount_r;
  assign out_set_empty    = empty_r;

endmodule

/* rtl/core/bounded_set_store.sv */
// A request is handled by a scan of the entry RAM, one entry read per cycle, that stops
// at the first match or after the last stored entry; a delete that hits then reads
// the last entry and moves it into the freed slot. A stalled result holds the block.
// It takes no new request until the result of the last one is loaded for output.
// Reset (rst_n, synchronous) empties the set; the entry RAM is not cleared.
module bounded_set_store #(
  parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bss_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [bss_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_success,
  output logic [bss_pkg::MCOUNT_W-1:0]       out_member_count,
  output logic                               out_set_empty
);

  bss_pkg::cmd_t    cmd;
  bss_pkg::status_t status;

  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bss_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_success      (out_success),
    .out_member_count (out_member_count),
    .out_set_empty    (out_set_empty),
    .cmd              (cmd),
    .status           (status)
  );

endmodule

/* tb/bounded_set_store_checker.sv */
`timescale 1ns / 100ps
module bounded_set_store_checker #(
  parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bss_pkg::FUNC_W-1:0]    in_func,
  input  logic [bss_pkg::VALUE_W-1:0]   in_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_success,
  input  logic [bss_pkg::MCOUNT_W-1:0]  out_member_count,
  input  logic                          out_set_empty,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct packed {
    logic                         success;
    logic [bss_pkg::MCOUNT_W-1:0] member_count;
    logic                         set_empty;
  } set_reply_t;

  logic [bss_pkg::VALUE_W-1:0] members [CAPACITY];
  int                          member_total;
  set_reply_t                  reply_q [$];

  // Applies one request to the shadow set and returns the reply it should produce.
  function automatic set_reply_t apply_request(input logic [bss_pkg::FUNC_W-1:0] func,
                                               input logic [bss_pkg::VALUE_W-1:0] value);
    int         slot;
    int         k;
    set_reply_t r;
    slot = -1;
    for (k = 0; k < member_total; k++) begin
      if (members[k] == value) begin
        slot = k;
        break;
      end
    end
    r.success = 1'b0;
    case (func)
      bss_pkg::FUNC_INSERT: begin
        if (slot < 0 && member_total < CAPACITY) begin
          members[member_total] = value;
          member_total++;
          r.success = 1'b1;
        end
      end
      bss_pkg::FUNC_DELETE: begin
        if (slot >= 0) begin
          for (k = slot; k + 1 < member_total; k++) members[k] = members[k + 1];
          member_total--;
          r.success = 1'b1;
        end
      end
      bss_pkg::FUNC_QUERY: begin
        r.success = (slot >= 0);
      end
      default: begin
      end
    endcase
    r.member_count = bss_pkg::MCOUNT_W'(member_total);
    r.set_empty    = (member_total == 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    set_reply_t want;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      member_total = 0;
      reply_q.delete();
      outstanding <= 0;
    end else begin
      // The result side is handled first so that a request accepted on the same
      // edge can never be matched against its own reply.
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result with nothing pending: success %0b count %0d empty %0b",
                   $time, out_success, out_member_count, out_set_empty);
          errs++;
        end else begin
          want = reply_q.pop_front();
          if (out_success !== want.success) begin
            $display("%0t: success expected %0b got %0b", $time, want.success, out_success);
            errs++;
          end
          if (out_member_count !== want.member_count) begin
            $display("%0t: member_count expected %0d got %0d",
                     $time, want.member_count, out_member_count);
            errs++;
          end
          if (out_set_empty !== want.set_empty) begin
            $display("%0t: set_empty expected %0b got %0b", $time, want.set_empty, out_set_empty);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) reply_q.push_back(apply_request(in_func, in_value));
      outstanding <= reply_q.size();
    end
    mismatches <= mismatches + errs;
  end

endmodule

/* tb/bounded_set_store_tb.sv */
`timescale 1ns / 100ps
module bounded_set_store_tb;

  localparam int CAPACITY    = bss_pkg::CAPACITY_DEF;
  localparam int POOL_SIZE   = 48;
  localparam int LONG_HOLD   = 1500;
  localparam int CYCLE_LIMIT = 2_000_000;

  localparam logic [bss_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  logic [bss_pkg::FUNC_W-1:0]         in_func   = '0;
  logic signed [bss_pkg::VALUE_W-1:0] in_value  = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               out_success;
  logic [bss_pkg::MCOUNT_W-1:0]       out_member_count;
  logic                               out_set_empty;

  int mismatches;
  int outstanding;
  int send_idle    = 0;
  int recv_idle    = 0;
  int holds_asked  = 0;
  int holds_done   = 0;
  int hold_left    = 0;
  int cycle_count  = 0;

  logic [bss_pkg::VALUE_W-1:0] pool_vals [POOL_SIZE];
  logic [bss_pkg::VALUE_W-1:0] fill_vals [$];

  always #4 clk = ~clk;

  bounded_set_store #(.CAPACITY(CAPACITY)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_success      (out_success),
    .out_member_count (out_member_count),
    .out_set_empty    (out_set_empty)
  );

  bounded_set_store_checker #(.CAPACITY(CAPACITY)) set_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_success      (out_success),
    .out_member_count (out_member_count),
    .out_set_empty    (out_set_empty),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Result side: random stalls, or a long hold-off when one has been asked for.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall  <= 1'b1;
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Valid stays high from one request to the next unless an idle cycle is drawn.
  task automatic offer_request(input logic [bss_pkg::FUNC_W-1:0] func,
                               input logic [bss_pkg::VALUE_W-1:0] value);
    while (int'($urandom_range(99)) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_requests(input int n);
    int                          pick;
    logic [bss_pkg::FUNC_W-1:0]  func;
    logic [bss_pkg::VALUE_W-1:0] value;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)      func = bss_pkg::FUNC_INSERT;
      else if (pick < 70) func = bss_pkg::FUNC_DELETE;
      else if (pick < 95) func = bss_pkg::FUNC_QUERY;
      else                func = FUNC_UNUSED;
      // Drawing mostly from a small pool makes hits, duplicates and deletes likely.
      if ($urandom_range(99) < 80) value = pool_vals[$urandom_range(POOL_SIZE - 1)];
      else                         value = $urandom;
      offer_request(func, value);
    end
  endtask

  initial begin
    int                          idx;
    logic [bss_pkg::VALUE_W-1:0] value;

    pool_vals[0] = 32'h8000_0000;
    pool_vals[1] = 32'h7FFF_FFFF;
    pool_vals[2] = 32'h0000_0000;
    pool_vals[3] = 32'hFFFF_FFFF;
    pool_vals[4] = 32'h5555_5555;
    pool_vals[5] = 32'hAAAA_AAAA;
    for (int i = 6; i < POOL_SIZE; i++) pool_vals[i] = $urandom;

    repeat (5) @(posedge clk);
    rst_n     <= 1'b1;
    send_idle <= 33;
    recv_idle <= 70;
    @(posedge clk);

    // Directed: empty set, extremes, duplicates, compaction from the front and the
    // back, the unused request kind, and back to empty.
    offer_request(bss_pkg::FUNC_QUERY,  32'h0000_0000);
    offer_request(bss_pkg::FUNC_DELETE, 32'h0000_0005);
    offer_request(bss_pkg::FUNC_INSERT, 32'h8000_0000);
    offer_request(bss_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
    offer_request(bss_pkg::FUNC_INSERT, 32'h0000_0000);
    offer_request(bss_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
    offer_request(bss_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
    offer_request(bss_pkg::FUNC_QUERY,  32'h8000_0000);
    offer_request(bss_pkg::FUNC_QUERY,  32'h0000_0001);
    offer_request(bss_pkg::FUNC_DELETE, 32'h8000_0000);
    offer_request(bss_pkg::FUNC_QUERY,  32'h7FFF_FFFF);
    offer_request(bss_pkg::FUNC_QUERY,  32'hFFFF_FFFF);
    offer_request(bss_pkg::FUNC_QUERY,  32'h8000_0000);
    offer_request(FUNC_UNUSED,          32'h0000_0000);
    offer_request(FUNC_UNUSED,          32'h1234_5678);
    offer_request(bss_pkg::FUNC_DELETE, 32'hFFFF_FFFF);
    offer_request(bss_pkg::FUNC_DELETE, 32'hFFFF_FFFF);
    offer_request(bss_pkg::FUNC_DELETE, 32'h0000_0000);
    offer_request(bss_pkg::FUNC_DELETE, 32'h7FFF_FFFF);
    offer_request(bss_pkg::FUNC_QUERY,  32'h7FFF_FFFF);
    offer_request(bss_pkg::FUNC_INSERT, 32'h5555_5555);
    offer_request(bss_pkg::FUNC_INSERT, 32'hAAAA_AAAA);

    random_requests(80);
    // Hold the result side off while requests keep coming, so the block backs up.
    holds_asked <= holds_asked + 1;
    random_requests(140);
    wait_for_replies();

    send_idle <= 70;
    recv_idle <= 33;
    random_requests(220);
    wait_for_replies();

    send_idle <= 0;
    recv_idle <= 0;
    // Fill to capacity with fresh values, then poke at the full set.
    for (int i = 0; i < CAPACITY + 14; i++) begin
      value = $urandom;
      fill_vals.push_back(value);
      offer_request(bss_pkg::FUNC_INSERT, value);
    end
    for (int i = 0; i < 3; i++) begin
      offer_request(bss_pkg::FUNC_INSERT, $urandom);
      offer_request(bss_pkg::FUNC_INSERT, fill_vals[$urandom_range(fill_vals.size() - 1)]);
      offer_request(bss_pkg::FUNC_QUERY,  fill_vals[$urandom_range(fill_vals.size() - 1)]);
      offer_request(FUNC_UNUSED,          $urandom);
    end
    offer_request(bss_pkg::FUNC_DELETE, fill_vals[0]);
    offer_request(bss_pkg::FUNC_INSERT, fill_vals[0]);
    offer_request(bss_pkg::FUNC_INSERT, $urandom);

    // Drain in random order, then clear whatever pool values are left.
    while (fill_vals.size() != 0) begin
      idx   = $urandom_range(fill_vals.size() - 1);
      value = fill_vals[idx];
      fill_vals.delete(idx);
      offer_request(bss_pkg::FUNC_DELETE, value);
    end
    for (int i = 0; i < POOL_SIZE; i++) offer_request(bss_pkg::FUNC_DELETE, pool_vals[i]);
    offer_request(bss_pkg::FUNC_QUERY, pool_vals[0]);
    random_requests(100);

    wait_for_replies();
    repeat (CAPACITY + 16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
